// ----- rtl/moving_window_mean_defines.svh -----
// Assertion macros used by the controller (mwm_ctrl).
`ifndef MOVING_WINDOW_MEAN_DEFINES_SVH
`define MOVING_WINDOW_MEAN_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define MWM_ASSERT_IMP(label, ck, rstn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("moving_window_mean: assertion failed");

`define MWM_ASSERT_NXT(label, ck, rstn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("moving_window_mean: assertion failed");

`else

`define MWM_ASSERT_IMP(label, ck, rstn, ante, cons)

`define MWM_ASSERT_NXT(label, ck, rstn, ante, cons)

`endif

`endif

// ----- rtl/mwm_pkg.sv -----
package mwm_pkg;

  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 32;

  localparam int WL_W       = 7;
  localparam int HC_W       = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam int ADDR_W  = $clog2(MAX_WINDOW);
  localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W   = (WL_W > CNT_W) ? WL_W : CNT_W;
  localparam int PROD_W  = SAMPLE_BITS + CNT_W + 1;
  localparam int SUM_W   = SAMPLE_BITS + CNT_W;
  localparam int WSUM_W  = SAMPLE_BITS + 2 * CNT_W;
  localparam int DIVD_W  = WSUM_W;
  localparam int DVS_W   = 2 * CNT_W;
  localparam int DCNT_W  = $clog2(DIVD_W + 1);

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHTING_MODE = 2'd1;

  localparam logic [WL_W-1:0] WL_RESET = 7'd8;

  typedef struct packed {
    logic accept;
    logic walk;
    logic div_start;
    logic div_sel_w;
    logic cap_simple;
    logic cap_weighted;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic len_zero;
    logic walk_last;
    logic pipe_busy;
    logic div_busy;
    logic div_done;
    logic mode_w;
  } dp_sts_t;

endpackage

// ----- rtl/mwm_ram.sv -----
module mwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/mwm_div.sv -----
module mwm_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [mwm_pkg::DIVD_W-1:0] dividend,
  input  logic [mwm_pkg::DVS_W-1:0]  divisor,
  output logic                       busy,
  output logic                       done,
  output logic [mwm_pkg::DIVD_W-1:0] quotient
);

  logic                       busy_r;
  logic                       done_r;
  logic [mwm_pkg::DCNT_W-1:0] cnt_r;
  logic [mwm_pkg::DIVD_W-1:0] quo_r;
  logic [mwm_pkg::DVS_W-1:0]  rem_r;
  logic [mwm_pkg::DVS_W-1:0]  dvs_r;
  logic [mwm_pkg::DVS_W:0]    shifted;
  logic [mwm_pkg::DVS_W:0]    diff;
  logic                       ge;
  logic [mwm_pkg::DVS_W-1:0]  rem_nxt;

  always_comb begin
    shifted = {rem_r, quo_r[mwm_pkg::DIVD_W-1]};
    diff    = shifted - {1'b0, dvs_r};
    ge      = (shifted >= {1'b0, dvs_r});
    rem_nxt = ge ? diff[mwm_pkg::DVS_W-1:0] : shifted[mwm_pkg::DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= mwm_pkg::DCNT_W'(mwm_pkg::DIVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == mwm_pkg::DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[mwm_pkg::DIVD_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- rtl/mwm_dp.sv -----
module mwm_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [mwm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mwm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [mwm_pkg::SAMPLE_BITS-1:0] in_sample,
  input  mwm_pkg::ctrl_cmd_t              cmd,
  output mwm_pkg::dp_sts_t                sts,
  output logic [mwm_pkg::SAMPLE_BITS-1:0] out_simple_mean,
  output logic [mwm_pkg::SAMPLE_BITS-1:0] out_weighted_mean,
  output logic [mwm_pkg::HC_W-1:0]        out_held_count
);

  localparam int SB = mwm_pkg::SAMPLE_BITS;

  logic [mwm_pkg::WL_W-1:0]   wl_r;
  logic                       mode_r;
  logic [mwm_pkg::ADDR_W-1:0] ws_r;
  logic                       full_r;

  logic [mwm_pkg::CMP_W-1:0]  wl_ext;
  logic [mwm_pkg::CNT_W-1:0]  len;
  logic                       len_zero;
  logic [mwm_pkg::CNT_W-1:0]  slot;
  logic [mwm_pkg::CNT_W-1:0]  slot_inc;
  logic                       wrap;
  logic [mwm_pkg::ADDR_W-1:0] ws_nxt;
  logic                       full_nxt;
  logic [mwm_pkg::CNT_W-1:0]  n_acc;
  logic [mwm_pkg::ADDR_W-1:0] ini;

  logic [mwm_pkg::CNT_W-1:0]  n_r;
  logic [mwm_pkg::CNT_W-1:0]  cnt_r;
  logic [mwm_pkg::CNT_W-1:0]  cnt_inc;
  logic [mwm_pkg::ADDR_W-1:0] rd_ptr_r;
  logic [mwm_pkg::CNT_W-1:0]  ptr_inc;
  logic                       p1_v_r;
  logic                       p2_v_r;
  logic [mwm_pkg::CNT_W-1:0]  w1_r;

  logic [SB-1:0]              rd_data;
  logic signed [SB-1:0]       rd_s;
  logic signed [mwm_pkg::CNT_W:0] w_s;
  logic signed [mwm_pkg::PROD_W-1:0] prod_nxt;
  logic [SB-1:0]              x_r;
  logic [mwm_pkg::PROD_W-1:0] prod_r;
  logic [mwm_pkg::SUM_W-1:0]  sum_r;
  logic [mwm_pkg::WSUM_W-1:0] wsum_r;
  logic [mwm_pkg::DVS_W-1:0]  nn;
  logic [mwm_pkg::DVS_W-1:0]  d_r;

  logic [mwm_pkg::SUM_W-1:0]  sum_mag;
  logic [mwm_pkg::WSUM_W-1:0] wsum_mag;
  logic [mwm_pkg::DIVD_W-1:0] div_dvd;
  logic [mwm_pkg::DVS_W-1:0]  div_dvs;
  logic [mwm_pkg::DIVD_W-1:0] div_q;
  logic                       div_busy;
  logic                       div_done;
  logic [mwm_pkg::DIVD_W-1:0] q_s;
  logic [mwm_pkg::DIVD_W-1:0] q_w;

  logic [SB-1:0]              smean_r;
  logic [SB-1:0]              wmean_r;
  logic [SB-1:0]              out_smean_r;
  logic [SB-1:0]              out_wmean_r;
  logic [mwm_pkg::CMP_W-1:0]  out_hc_r;

  always_comb begin
    wl_ext = mwm_pkg::CMP_W'(wl_r);
    if (wl_ext > mwm_pkg::CMP_W'(mwm_pkg::MAX_WINDOW)) begin
      len = mwm_pkg::CNT_W'(mwm_pkg::MAX_WINDOW);
    end else begin
      len = mwm_pkg::CNT_W'(wl_ext);
    end
    len_zero = (len == '0);
    slot     = (mwm_pkg::CNT_W'(ws_r) >= len) ? '0 : mwm_pkg::CNT_W'(ws_r);
    slot_inc = slot + 1'b1;
    wrap     = (slot_inc >= len);
    ws_nxt   = wrap ? '0 : slot_inc[mwm_pkg::ADDR_W-1:0];
    full_nxt = full_r | wrap;
    n_acc    = full_nxt ? len : slot_inc;
    ini      = full_nxt ? ws_nxt : '0;
    cnt_inc  = cnt_r + 1'b1;
    ptr_inc  = mwm_pkg::CNT_W'(rd_ptr_r) + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r   <= mwm_pkg::WL_RESET;
      mode_r <= 1'b0;
      ws_r   <= '0;
      full_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        mwm_pkg::REG_WINDOW_LENGTH: begin
          wl_r   <= cfg_data[mwm_pkg::WL_W-1:0];
          ws_r   <= '0;
          full_r <= 1'b0;
        end
        mwm_pkg::REG_WEIGHTING_MODE: begin
          mode_r <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end else if (cmd.accept && !len_zero) begin
      ws_r   <= ws_nxt;
      full_r <= full_nxt;
    end
  end

  mwm_ram #(
    .WIDTH(SB),
    .DEPTH(mwm_pkg::MAX_WINDOW)
  ) u_ring (
    .clk  (clk),
    .we   (cmd.accept && !len_zero),
    .waddr(slot[mwm_pkg::ADDR_W-1:0]),
    .wdata(in_sample),
    .raddr(rd_ptr_r),
    .rdata(rd_data)
  );

  always_comb begin
    rd_s     = rd_data;
    w_s      = {1'b0, w1_r};
    prod_nxt = mwm_pkg::PROD_W'(rd_s) * mwm_pkg::PROD_W'(w_s);
    nn       = mwm_pkg::DVS_W'(n_r) * (mwm_pkg::DVS_W'(n_r) + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
    end else begin
      p1_v_r <= cmd.walk;
      p2_v_r <= p1_v_r;
    end
  end

  always_comb begin
    sum_mag  = sum_r[mwm_pkg::SUM_W-1] ? (~sum_r + 1'b1) : sum_r;
    wsum_mag = wsum_r[mwm_pkg::WSUM_W-1] ? (~wsum_r + 1'b1) : wsum_r;
    div_dvd  = cmd.div_sel_w ? wsum_mag : mwm_pkg::DIVD_W'(sum_mag);
    div_dvs  = cmd.div_sel_w ? d_r : mwm_pkg::DVS_W'(n_r);
    q_s      = sum_r[mwm_pkg::SUM_W-1] ? (~div_q + 1'b1) : div_q;
    q_w      = wsum_r[mwm_pkg::WSUM_W-1] ? (~div_q + 1'b1) : div_q;
  end

  mwm_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .dividend(div_dvd),
    .divisor (div_dvs),
    .busy    (div_busy),
    .done    (div_done),
    .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    w1_r   <= cnt_inc;
    x_r    <= rd_data;
    prod_r <= prod_nxt;
    d_r    <= nn >> 1;
    if (cmd.accept) begin
      n_r      <= len_zero ? '0 : n_acc;
      cnt_r    <= '0;
      rd_ptr_r <= ini;
      sum_r    <= '0;
      wsum_r   <= '0;
      smean_r  <= '0;
      wmean_r  <= '0;
    end else begin
      if (cmd.walk) begin
        cnt_r    <= cnt_inc;
        rd_ptr_r <= (ptr_inc >= len) ? '0 : ptr_inc[mwm_pkg::ADDR_W-1:0];
      end
      if (p2_v_r) begin
        sum_r  <= sum_r + {{(mwm_pkg::SUM_W - SB){x_r[SB-1]}}, x_r};
        wsum_r <= wsum_r + {{(mwm_pkg::WSUM_W - mwm_pkg::PROD_W){prod_r[mwm_pkg::PROD_W-1]}},
                            prod_r};
      end
      if (cmd.cap_simple) begin
        smean_r <= q_s[SB-1:0];
      end
      if (cmd.cap_weighted) begin
        wmean_r <= q_w[SB-1:0];
      end
    end
    if (cmd.load_out) begin
      out_smean_r <= smean_r;
      out_wmean_r <= wmean_r;
      out_hc_r    <= mwm_pkg::CMP_W'(n_r);
    end
  end

  always_comb begin
    sts.len_zero  = len_zero;
    sts.walk_last = (cnt_inc == n_r);
    sts.pipe_busy = p1_v_r | p2_v_r;
    sts.div_busy  = div_busy;
    sts.div_done  = div_done;
    sts.mode_w    = mode_r;
  end

  assign out_simple_mean   = out_smean_r;
  assign out_weighted_mean = out_wmean_r;
  assign out_held_count    = out_hc_r[mwm_pkg::HC_W-1:0];

endmodule

// ----- rtl/mwm_ctrl.sv -----
`include "moving_window_mean_defines.svh"

module mwm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  mwm_pkg::dp_sts_t   sts,
  output mwm_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_WALK  = 6'b000010,
    S_DRAIN = 6'b000100,
    S_DIVS  = 6'b001000,
    S_DIVW  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.len_zero ? S_DONE : S_WALK;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIVS;
        end
      end
      S_DIVS: begin
        if (sts.div_done) begin
          cmd.cap_simple = 1'b1;
          if (sts.mode_w) begin
            cmd.div_start = 1'b1;
            cmd.div_sel_w = 1'b1;
            state_nxt     = S_DIVW;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DIVW: begin
        if (sts.div_done) begin
          cmd.cap_weighted = 1'b1;
          state_nxt        = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  `MWM_ASSERT_IMP(a_div_start_clean, clk, rst_n, cmd.div_start, !sts.pipe_busy && !sts.div_busy)
  `MWM_ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.load_out, !out_valid_r || out_ready)
  `MWM_ASSERT_NXT(a_zero_skip, clk, rst_n, cmd.accept && sts.len_zero, state_r == S_DONE)

endmodule

// ----- rtl/moving_window_mean.sv -----
// Each accepted sample is written into a ring of up to 64 entries whose length is set by
// window_length, and one result follows with the truncated mean of the samples held, the
// linearly weighted mean (oldest weight 1, newest weight n, divided by n(n+1)/2; zero
// unless weighting_mode is 1) and the held count n. A window length of 0 ignores the sample
// and returns zeros, and writing it empties the ring. For each item the ring is read one entry
// a cycle through a multiply-accumulate pipeline, and each of the one or two divisions (the
// second only in weighted mode) runs a bit a cycle over a 46-bit dividend. Configuration
// writes are taken at once and belong between items only.
module moving_window_mean (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mwm_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mwm_pkg::SAMPLE_BITS-1:0] out_simple_mean,
  output logic [mwm_pkg::SAMPLE_BITS-1:0] out_weighted_mean,
  output logic [mwm_pkg::HC_W-1:0]        out_held_count,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mwm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mwm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  mwm_pkg::ctrl_cmd_t cmd;
  mwm_pkg::dp_sts_t   sts;

  assign cfg_ready = 1'b1;

  mwm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mwm_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_sample        (in_sample),
    .cmd              (cmd),
    .sts              (sts),
    .out_simple_mean  (out_simple_mean),
    .out_weighted_mean(out_weighted_mean),
    .out_held_count   (out_held_count)
  );

endmodule
